// File: rtl/flha_pkg.sv
// Shared field widths and request, fit and status codes of the free-list heap allocator.
package flha_pkg;

    localparam int CFG_W = 13;
    localparam int REQ_W = 13;
    localparam int FIT_W = 2;
    localparam int OFF_W = 12;
    localparam int ST_W  = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [FIT_W-1:0] FIT_BEST  = 2'd0;
    localparam logic [FIT_W-1:0] FIT_WORST = 2'd1;
    localparam logic [FIT_W-1:0] FIT_FIRST = 2'd2;
    localparam logic [FIT_W-1:0] FIT_BAD   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BADARG  = 2'd2;

endpackage

// File: rtl/flha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module flha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/free_list_heap_allocator.sv
// Free-list heap allocator: best, worst and first fit with split and address-order merge.
// An allocate walks the free-list headers, at most one per granule, reading and evaluating each.
// A free pushes the block onto the list head, then walks on from it merging adjacent successors.
// One request is in flight at a time; the header memory's single read port sets the pace.
// Reset is synchronous; the init state entered on reset writes the header of the whole region.
// Stall is high in that init state, while a register write is presented and while a
// request is being worked on.
module free_list_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [flha_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [flha_pkg::REQ_W-1:0]    i_request_bytes,
    input  logic [flha_pkg::FIT_W-1:0]    i_fit_style,
    input  logic [flha_pkg::OFF_W-1:0]    i_payload_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [flha_pkg::OFF_W-1:0]    o_granted_offset,
    output logic [flha_pkg::ST_W-1:0]     o_status
);
    import flha_pkg::*;

    localparam int GRAN     = HEAP_BYTES / ALIGN_BYTES;
    localparam int IW       = $clog2(GRAN);
    localparam int GW       = IW + 1;
    localparam int ASH      = $clog2(ALIGN_BYTES);
    localparam int SIZE_CAP = 2 * HEAP_BYTES - 1;
    localparam int SW       = $clog2(2 * HEAP_BYTES);
    localparam int NW       = (SW + 1 > REQ_W + 2) ? SW + 1 : REQ_W + 2;
    localparam int XW       = NW + GW + ASH + 1;
    localparam int STEP_W   = $clog2(2 * GRAN) + 1;
    localparam int RW       = $clog2(HEAP_BYTES + 1);
    localparam int CW       = ((RW > CFG_W) ? RW : CFG_W) + 1;
    localparam int FW       = OFF_W + 2;
    localparam logic [GW-1:0] NIL = GW'(GRAN);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_RD, S_A_EV, S_A_PICK, S_A_SPL2, S_A_UNL,
        S_F_PUSH, S_F_RD, S_F_EV1, S_F_EV2, S_OUT
    } t_state;

    t_state              r_state;
    logic [RW-1:0]       r_region;
    logic [GW-1:0]       r_head;
    logic [FIT_W-1:0]    r_style;
    logic [NW-1:0]       r_need;
    logic [GW-1:0]       r_cur;
    logic [GW-1:0]       r_prev;
    logic [GW-1:0]       r_pick;
    logic [GW-1:0]       r_pick_prev;
    logic [GW-1:0]       r_pick_nx;
    logic [SW-1:0]       r_pick_sz;
    logic [SW-1:0]       r_cur_sz;
    logic [GW-1:0]       r_nx;
    logic [GW-1:0]       r_unl_nx;
    logic [STEP_W-1:0]   r_steps;
    logic [OFF_W-1:0]    r_res_off;
    logic [ST_W-1:0]     r_res_st;
    logic                r_o_valid;
    logic [OFF_W-1:0]    r_o_off;
    logic [ST_W-1:0]     r_o_st;

    // Header memory ports.
    logic              sz_we;
    logic [IW-1:0]     sz_wa;
    logic [SW-1:0]     sz_wd;
    logic [SW-1:0]     sz_q;
    logic              nx_we;
    logic [IW-1:0]     nx_wa;
    logic [GW-1:0]     nx_wd;
    logic [GW-1:0]     nx_q;
    logic [IW-1:0]     rd_addr;

    flha_ram #(.WIDTH(SW), .DEPTH(GRAN)) u_size_ram (
        .i_clk(i_clk), .i_we(sz_we), .i_waddr(sz_wa), .i_wdata(sz_wd),
        .i_raddr(rd_addr), .o_rdata(sz_q)
    );

    flha_ram #(.WIDTH(GW), .DEPTH(GRAN)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(rd_addr), .o_rdata(nx_q)
    );

    // Region write: clamp to two headers .. heap size, then align down.
    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] cfg_lim;
    logic [RW-1:0] cfg_clamp;
    always_comb begin
        cfg_ext = CW'(i_cfg_data);
        cfg_lim = cfg_ext;
        if (cfg_ext < CW'(2 * HEADER_BYTES)) begin
            cfg_lim = CW'(2 * HEADER_BYTES);
        end else if (cfg_ext > CW'(HEAP_BYTES)) begin
            cfg_lim = CW'(HEAP_BYTES);
        end
        cfg_clamp = RW'({cfg_lim[CW-1:ASH], ASH'(0)});
    end

    // Request decode: rounded allocation size and header granule of a free.
    logic [NW-1:0] need_sum;
    logic [NW-1:0] need_c;
    logic [FW-1:0] off_sum;
    logic [FW-1:0] off_up;
    logic [FW-1:0] hdr_g;
    always_comb begin
        need_sum = NW'(i_request_bytes) + NW'(ALIGN_BYTES - 1);
        need_c   = {need_sum[NW-1:ASH], ASH'(0)};
        off_sum  = FW'(i_payload_offset) + FW'(ALIGN_BYTES - 1);
        off_up   = {off_sum[FW-1:ASH], ASH'(0)};
        hdr_g    = (off_up - FW'(HEADER_BYTES)) >> ASH;
    end

    // Walk evaluation: does the header just read fit, and should it be taken.
    logic fit;
    logic take;
    always_comb begin
        fit  = NW'(sz_q) >= r_need;
        take = fit && ((r_pick == NIL) || (r_style == FIT_FIRST) ||
                       (r_style == FIT_BEST && sz_q < r_pick_sz) ||
                       (r_style == FIT_WORST && sz_q > r_pick_sz));
    end

    // Split of the chosen block and the granted offset.
    logic          split_fit;
    logic [XW-1:0] nb_w;
    logic          nb_ok;
    logic [NW:0]   rem_sz;
    logic [XW-1:0] grant_w;
    always_comb begin
        split_fit = (NW + 1)'(r_pick_sz) >= (NW + 1)'(r_need) + (NW + 1)'(HEADER_BYTES);
        nb_w      = ((XW'(r_pick) << ASH) + XW'(HEADER_BYTES) + XW'(r_need)) >> ASH;
        nb_ok     = nb_w < XW'(GRAN);
        rem_sz    = (NW + 1)'(r_pick_sz) - (NW + 1)'(r_need) - (NW + 1)'(HEADER_BYTES);
        grant_w   = (XW'(r_pick) << ASH) + XW'(HEADER_BYTES);
    end

    // Merge test against the successor and the saturated merged size.
    logic          adjacent;
    logic [SW+1:0] msum;
    logic [SW-1:0] msat;
    always_comb begin
        adjacent = (XW'(r_cur) << ASH) + XW'(r_cur_sz) + XW'(HEADER_BYTES) ==
                   (XW'(r_nx) << ASH);
        msum     = (SW + 2)'(r_cur_sz) + (SW + 2)'(sz_q) + (SW + 2)'(HEADER_BYTES);
        msat     = (msum > (SW + 2)'(SIZE_CAP)) ? SW'(SIZE_CAP) : SW'(msum);
    end

    // Header memory port control.
    always_comb begin
        sz_we   = 1'b0;
        sz_wa   = '0;
        sz_wd   = '0;
        nx_we   = 1'b0;
        nx_wa   = '0;
        nx_wd   = NIL;
        rd_addr = r_cur[IW-1:0];
        unique case (r_state)
            S_INIT: begin
                sz_we = 1'b1;
                sz_wd = SW'(r_region - RW'(HEADER_BYTES));
                nx_we = 1'b1;
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    sz_we = 1'b1;
                    sz_wd = SW'(cfg_clamp - RW'(HEADER_BYTES));
                    nx_we = 1'b1;
                end
            end
            S_A_PICK: begin
                if (r_pick != NIL && split_fit && nb_ok) begin
                    sz_we = 1'b1;
                    sz_wa = nb_w[IW-1:0];
                    sz_wd = SW'(rem_sz);
                    nx_we = 1'b1;
                    nx_wa = nb_w[IW-1:0];
                    nx_wd = r_pick_nx;
                end
            end
            S_A_SPL2: begin
                sz_we = 1'b1;
                sz_wa = r_pick[IW-1:0];
                sz_wd = SW'(r_need);
                nx_we = 1'b1;
                nx_wa = r_pick[IW-1:0];
                nx_wd = r_unl_nx;
            end
            S_A_UNL: begin
                if (r_pick_prev != NIL) begin
                    nx_we = 1'b1;
                    nx_wa = r_pick_prev[IW-1:0];
                    nx_wd = r_unl_nx;
                end
            end
            S_F_PUSH: begin
                nx_we = 1'b1;
                nx_wa = r_cur[IW-1:0];
                nx_wd = r_head;
            end
            S_F_EV1: begin
                rd_addr = nx_q[IW-1:0];
            end
            S_F_EV2: begin
                if (adjacent) begin
                    sz_we = 1'b1;
                    sz_wa = r_cur[IW-1:0];
                    sz_wd = msat;
                    nx_we = 1'b1;
                    nx_wa = r_cur[IW-1:0];
                    nx_wd = nx_q;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, list state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_region  <= RW'(HEAP_BYTES);
            r_head    <= '0;
            r_o_valid <= 1'b0;
            r_steps   <= '0;
        end else begin
            // The hand-over state loads the output register itself.
            if (r_o_valid && !i_out_stall && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_head  <= '0;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_region <= cfg_clamp;
                        r_head   <= '0;
                    end else if (i_in_valid) begin
                        r_style     <= i_fit_style;
                        r_need      <= need_c;
                        r_prev      <= NIL;
                        r_pick      <= NIL;
                        r_pick_prev <= NIL;
                        r_steps     <= '0;
                        r_res_off   <= '0;
                        if (i_func == FUNC_ALLOC) begin
                            r_cur <= r_head;
                            priority if (i_request_bytes == '0) begin
                                r_res_st <= ST_BADARG;
                                r_state  <= S_OUT;
                            end else if (r_head >= NIL) begin
                                r_res_st <= ST_NOSPACE;
                                r_state  <= S_OUT;
                            end else if (i_fit_style == FIT_BAD) begin
                                r_res_st <= ST_BADARG;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_A_RD;
                            end
                        end else begin
                            r_cur <= GW'(hdr_g);
                            if (i_payload_offset < OFF_W'(HEADER_BYTES) ||
                                hdr_g >= FW'(GRAN)) begin
                                r_res_st <= ST_BADARG;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_F_PUSH;
                            end
                        end
                    end
                end
                S_A_RD: begin
                    if (r_steps == STEP_W'(GRAN) || r_cur >= NIL) begin
                        r_state <= S_A_PICK;
                    end else begin
                        r_state <= S_A_EV;
                    end
                end
                S_A_EV: begin
                    if (take) begin
                        r_pick      <= r_cur;
                        r_pick_prev <= r_prev;
                        r_pick_sz   <= sz_q;
                        r_pick_nx   <= nx_q;
                    end
                    if (fit && r_style == FIT_FIRST) begin
                        r_state <= S_A_PICK;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= nx_q;
                        r_steps <= r_steps + STEP_W'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_A_PICK: begin
                    if (r_pick == NIL) begin
                        r_res_st <= ST_NOSPACE;
                        r_state  <= S_OUT;
                    end else if (split_fit && nb_ok) begin
                        r_unl_nx <= GW'(nb_w);
                        r_state  <= S_A_SPL2;
                    end else begin
                        r_unl_nx <= r_pick_nx;
                        r_state  <= S_A_UNL;
                    end
                end
                S_A_SPL2: begin
                    r_state <= S_A_UNL;
                end
                S_A_UNL: begin
                    if (r_pick_prev == NIL) begin
                        r_head <= r_unl_nx;
                    end
                    r_res_off <= grant_w[OFF_W-1:0];
                    r_res_st  <= ST_OK;
                    r_state   <= S_OUT;
                end
                S_F_PUSH: begin
                    r_head  <= r_cur;
                    r_state <= S_F_RD;
                end
                S_F_RD: begin
                    if (r_steps == STEP_W'(2 * GRAN) || r_cur >= NIL) begin
                        r_res_st <= ST_OK;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_F_EV1;
                    end
                end
                S_F_EV1: begin
                    r_cur_sz <= sz_q;
                    r_nx     <= nx_q;
                    if (nx_q >= NIL) begin
                        r_res_st <= ST_OK;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_F_EV2;
                    end
                end
                S_F_EV2: begin
                    if (!adjacent) begin
                        r_cur <= r_nx;
                    end
                    r_steps <= r_steps + STEP_W'(1);
                    r_state <= S_F_RD;
                end
                S_OUT: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_off   <= r_res_off;
                        r_o_st    <= r_res_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A register write takes the idle cycle, so no request is taken alongside it.
    assign o_in_stall       = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid      = r_o_valid;
    assign o_granted_offset = r_o_off;
    assign o_status         = r_o_st;

    // An error result never carries an offset.
    a_err_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_granted_offset == '0)
        else $error("error result with a non-zero offset");

    // A header is only evaluated for a granule inside the memory.
    a_eval_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_EV || r_state == S_F_EV1) |-> r_cur < NIL)
        else $error("walk evaluated a null granule");

    // The walk counter never passes the merge-walk bound.
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(2 * GRAN))
        else $error("walk step counter overran");

    // A result appears only when the sequencer hands one over.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result appeared outside the hand-over state");

endmodule
